[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hdl/ddw_pkg.sv]
package ddw_pkg;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int TRIG_ITER_DEF  = 16;
    localparam int ATAN_ENTRIES   = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FAST_TOP  = 3'd0,
        REG_FAST_LOOK = 3'd1,
        REG_SLOW_TOP  = 3'd2,
        REG_SLOW_LOOK = 3'd3,
        REG_RADIUS    = 3'd4,
        REG_SPACING   = 3'd5,
        REG_HYST      = 3'd6,
        REG_LIMIT     = 3'd7
    } cfg_reg_t;

    localparam logic [15:0] RST_FAST_TOP  = 16'd39322;
    localparam logic [15:0] RST_FAST_LOOK = 16'd5308;
    localparam logic [15:0] RST_SLOW_TOP  = 16'd26214;
    localparam logic [15:0] RST_SLOW_LOOK = 16'd6554;
    localparam logic [15:0] RST_RADIUS    = 16'd1049;
    localparam logic [15:0] RST_SPACING   = 16'd4915;
    localparam logic [14:0] RST_HYST      = 15'd13107;
    localparam logic [14:0] RST_LIMIT     = 15'd15360;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic signed [15:0] heading_target;
        logic signed [15:0] robot_heading;
        logic [1:0]         speed_level;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] left_wheel_rate;
        logic signed [15:0] right_wheel_rate;
        logic               reverse_drive;
    } out_word_t;

    function automatic logic [31:0] atan_q32(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
            5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
            5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
            5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
            5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
            5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
            5'd20: r = 32'd652;       5'd21: r = 32'd326;
            5'd22: r = 32'd163;       5'd23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction
endpackage

[hdl/ddw_in_if.sv]
interface ddw_in_if;
    logic               valid;
    logic               ready;
    ddw_pkg::in_word_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/ddw_out_if.sv]
interface ddw_out_if;
    logic               valid;
    logic               ready;
    ddw_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/diff_drive_heading_to_wheels.sv]
// Differential-drive wheel commander.
// Input channel in_ch carries a word with the target heading, the robot
// heading and a speed level; output channel out_ch returns one word with the
// left and right wheel rates (Q7.8) and the drive-side flag for each input.
// Both channels use valid/ready; a word moves when both are high.
// The configuration port (cfg_we, cfg_idx, cfg_data) writes one of the eight
// registers per cycle; write it only while the block is idle.
// After an input word is accepted, the block runs the CORDIC iterations on one
// add/shift unit, a rounding step, the multiply states through one 32x32
// multiplier, and, for each wheel, a 17-step restoring divider with its load
// and finish states; the result then appears on out_ch.
// in_ch.ready is low from acceptance until the result has been taken, so the
// block takes no new word while an earlier one is still in progress.
// If the receiver stalls, the result is held in the output register and no
// new word is taken. Reset restores register defaults and sets the drive side
// to forward; no clearing pass is needed.
module diff_drive_heading_to_wheels #(
    parameter int ANGLE_BITS      = ddw_pkg::ANGLE_BITS_DEF,
    parameter int TRIG_ITERATIONS = ddw_pkg::TRIG_ITER_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    ddw_in_if.sink                           in_ch,
    ddw_out_if.source                        out_ch,
    input  logic                             cfg_we,
    input  logic [ddw_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [ddw_pkg::CFG_DATA_W-1:0]   cfg_data
);
    localparam int IT_W = $clog2(TRIG_ITERATIONS + 1);
    localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    typedef enum logic [3:0] {
        S_IDLE, S_CORDIC, S_ROUND, S_MUL_A, S_MUL_B, S_MUL_C, S_MUL_D, S_DEN,
        S_DIV_LOAD, S_DIV, S_OUT
    } state_t;

    // Configuration registers.
    logic [15:0] fast_top_reg, fast_look_reg, slow_top_reg, slow_look_reg;
    logic [15:0] radius_reg, spacing_reg;
    logic [14:0] hyst_reg, limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_top_reg  <= ddw_pkg::RST_FAST_TOP;
            fast_look_reg <= ddw_pkg::RST_FAST_LOOK;
            slow_top_reg  <= ddw_pkg::RST_SLOW_TOP;
            slow_look_reg <= ddw_pkg::RST_SLOW_LOOK;
            radius_reg    <= ddw_pkg::RST_RADIUS;
            spacing_reg   <= ddw_pkg::RST_SPACING;
            hyst_reg      <= ddw_pkg::RST_HYST;
            limit_reg     <= ddw_pkg::RST_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (ddw_pkg::cfg_reg_t'(cfg_idx))
                ddw_pkg::REG_FAST_TOP:  fast_top_reg  <= cfg_data;
                ddw_pkg::REG_FAST_LOOK: fast_look_reg <= cfg_data;
                ddw_pkg::REG_SLOW_TOP:  slow_top_reg  <= cfg_data;
                ddw_pkg::REG_SLOW_LOOK: slow_look_reg <= cfg_data;
                ddw_pkg::REG_RADIUS:    radius_reg    <= cfg_data;
                ddw_pkg::REG_SPACING:   spacing_reg   <= cfg_data;
                ddw_pkg::REG_HYST:      hyst_reg      <= cfg_data[14:0];
                ddw_pkg::REG_LIMIT:     limit_reg     <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    state_t state_reg;
    logic [IT_W-1:0] iter_reg;
    logic [4:0] bit_reg;
    logic side_reg, flip_reg, second_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic signed [16:0] c_reg, s_reg;
    logic [15:0] top_reg, look_reg, rad_reg;
    logic signed [63:0] fwd_reg, turn_reg, num_reg;
    logic [63:0] rem_reg, dsh_reg;
    logic [47:0] den_reg;
    logic [16:0] quo_reg;
    logic neg_reg;
    logic signed [15:0] right_reg;
    logic out_valid_reg;
    ddw_pkg::out_word_t out_reg;

    // Shared datapath pieces.
    logic signed [33:0] xs, ys, cx, cy;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic [31:0] ang;
    logic [15:0] diff;
    logic slow_sel;
    logic [15:0] look_sel;
    logic [64:0] trial;
    logic [16:0] q_round;
    logic [15:0] q_sat;
    logic signed [15:0] rate;
    logic [63:0] mag_abs;

    assign xs = x_reg >>> iter_reg;
    assign ys = y_reg >>> iter_reg;
    assign diff = in_ch.data.heading_target - in_ch.data.robot_heading;
    assign ang = {diff, 16'd0} & ANG_MASK;
    assign slow_sel = in_ch.data.speed_level == 2'd3;
    assign look_sel = slow_sel ? slow_look_reg : fast_look_reg;
    assign cx = (x_reg + 34'sd16384) >>> 15;
    assign cy = (y_reg + 34'sd16384) >>> 15;
    assign mul_p = mul_a * mul_b;
    assign trial = {1'b0, rem_reg} - {1'b0, dsh_reg};
    assign mag_abs = num_reg[63] ? 64'(-num_reg) : 64'(num_reg);

    // Round half away: the divider works on the magnitude plus half the
    // divisor. A quotient of 2^16 or more leaves its top bit set, which is
    // always above the limit and so saturates.
    assign q_round = quo_reg;
    assign q_sat = (q_round > {2'b0, limit_reg}) ? {1'b0, limit_reg} : quo_reg[15:0];
    assign rate = neg_reg ? -$signed(q_sat) : $signed(q_sat);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL_A: begin mul_a = {16'd0, top_reg}; mul_b = 32'(c_reg); end
            S_MUL_B: begin mul_a = {16'd0, top_reg}; mul_b = 32'(s_reg); end
            S_MUL_C: begin mul_a = fwd_reg[31:0]; mul_b = {16'd0, look_reg}; end
            S_MUL_D: begin mul_a = turn_reg[31:0]; mul_b = {16'd0, spacing_reg}; end
            S_DEN:   begin mul_a = {16'd0, rad_reg}; mul_b = {16'd0, look_reg}; end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            side_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
            bit_reg       <= '0;
            second_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && !out_valid_reg)
                    begin
                        flip_reg <= ang[31] ^ ang[30];
                        z_reg    <= (ang[31] ^ ang[30])
                                    ? 34'($signed(ang + 32'h8000_0000))
                                    : 34'($signed(ang));
                        x_reg    <= ddw_pkg::CORDIC_X0;
                        y_reg    <= '0;
                        iter_reg <= '0;
                        top_reg  <= slow_sel ? slow_top_reg : fast_top_reg;
                        look_reg <= (look_sel == 16'd0) ? 16'd1 : look_sel;
                        rad_reg  <= radius_reg == 16'd0 ? 16'd1 : radius_reg;
                        state_reg <= S_CORDIC;
                    end
                end
                S_CORDIC:
                begin
                    if (iter_reg == IT_W'(TRIG_ITERATIONS))
                        state_reg <= S_ROUND;
                    else
                    begin
                        if (!z_reg[33])
                        begin
                            x_reg <= x_reg - ys;
                            y_reg <= y_reg + xs;
                            z_reg <= z_reg - 34'(ddw_pkg::atan_q32(5'(iter_reg)));
                        end
                        else
                        begin
                            x_reg <= x_reg + ys;
                            y_reg <= y_reg - xs;
                            z_reg <= z_reg + 34'(ddw_pkg::atan_q32(5'(iter_reg)));
                        end
                        iter_reg <= iter_reg + 1'b1;
                    end
                end
                S_ROUND:
                begin
                    c_reg <= flip_reg ? -17'(cx) : 17'(cx);
                    s_reg <= flip_reg ? -17'(cy) : 17'(cy);
                    state_reg <= S_MUL_A;
                end
                S_MUL_A:
                begin
                    if (c_reg > $signed({2'b0, hyst_reg}))
                        side_reg <= 1'b0;
                    else if (c_reg < -$signed({2'b0, hyst_reg}))
                        side_reg <= 1'b1;
                    fwd_reg <= mul_p;
                    state_reg <= S_MUL_B;
                end
                S_MUL_B:
                begin
                    turn_reg <= side_reg ? mul_p : -mul_p;
                    state_reg <= S_MUL_C;
                end
                S_MUL_C:
                begin
                    // Both partial products fit in 32 signed bits.
                    fwd_reg <= mul_p;
                    state_reg <= S_MUL_D;
                end
                S_MUL_D:
                begin
                    turn_reg <= mul_p;
                    state_reg <= S_DEN;
                end
                S_DEN:
                begin
                    den_reg <= {9'd0, mul_p[31:0], 7'd0};
                    num_reg <= fwd_reg + turn_reg;
                    second_reg <= 1'b0;
                    state_reg <= S_DIV_LOAD;
                end
                S_DIV_LOAD:
                begin
                    neg_reg <= num_reg[63];
                    rem_reg <= mag_abs + {17'd0, den_reg[47:1]};
                    dsh_reg <= {den_reg, 16'd0};
                    quo_reg <= '0;
                    bit_reg <= 5'd0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // One quotient bit per cycle, most significant first.
                    if (!trial[64])
                        rem_reg <= trial[63:0];
                    dsh_reg <= dsh_reg >> 1;
                    quo_reg <= {quo_reg[15:0], ~trial[64]};
                    bit_reg <= bit_reg + 1'b1;
                    if (bit_reg == 5'd16)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // The first pass gives the right wheel; the second the left.
                    if (!second_reg)
                    begin
                        right_reg <= rate;
                        num_reg <= fwd_reg - turn_reg;
                        second_reg <= 1'b1;
                        state_reg <= S_DIV_LOAD;
                    end
                    else if (!out_valid_reg)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase

            if (state_reg == S_OUT && second_reg && !out_valid_reg)
            begin
                out_reg.left_wheel_rate  <= rate;
                out_reg.right_wheel_rate <= right_reg;
                out_reg.reverse_drive    <= side_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign in_ch.ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;
endmodule

[hdl/ddw_checker.sv]
`include "assert_macros.svh"
module ddw_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `ASSERT_IMPLIES(a_no_accept_while_full, clk, rst_n, out_valid, !in_ready)
    `ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_no_out_after_accept, clk, rst_n, in_valid && in_ready, !out_valid)
endmodule

bind diff_drive_heading_to_wheels ddw_checker u_ddw_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready)
);

[dv/tb.sv]
`timescale 1ns / 1ps

// Testbench for the differential-drive wheel commander.
// Each heading word is predicted in the testbench (CORDIC trig, hysteresis,
// wheel quotient with rounding and saturation). Every returned word is
// compared field by field against the oldest outstanding expected word.
module tb;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int NUM_PHASES = 10;
    localparam int WORDS_PER_PHASE = 155;
    localparam int DRAIN_CYCLES = 120;

    // One row of the directed table. When has_typed is set, the expected word
    // is given in the row rather than taken from the predictor.
    typedef struct {
        logic [15:0] target;
        logic [15:0] heading;
        logic [1:0]  level;
        bit          has_typed;
        logic [15:0] left;
        logic [15:0] right;
        logic        rev;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ddw_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [ddw_pkg::CFG_DATA_W-1:0] cfg_data;

    ddw_in_if in_ch ();
    ddw_out_if out_ch ();

    diff_drive_heading_to_wheels i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // Shadow copy of the configuration registers and of the drive-side flag.
    logic [15:0] reg_shadow [8];
    logic        side_reverse;

    ddw_pkg::out_word_t pending_wheel_cmds [$];
    dir_row_t           dir_rows [$];

    int          mismatches;
    int          words_sent;
    int          words_checked;
    int          cycle_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          typed_active;
    ddw_pkg::out_word_t typed_word;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Arctangent of 2^-i in units of 2^-32 turns.
    function automatic longint atan_turns(int i);
        unique case (i)
            0: return 536870912;   1: return 316933406;
            2: return 167458907;   3: return 85004756;
            4: return 42667331;    5: return 21354465;
            6: return 10679838;    7: return 5340245;
            8: return 2670163;     9: return 1335087;
            10: return 667544;     11: return 333772;
            12: return 166886;     13: return 83443;
            14: return 41722;      15: return 20861;
            default: return 0;
        endcase
    endfunction

    // Rounds num/den to nearest, ties away from zero, and clamps to +-lim.
    function automatic longint rounded_wheel(longint num, longint den, longint lim);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        if (num < 0)
            q = -q;
        if (q > lim)
            q = lim;
        if (q < -lim)
            q = -lim;
        return q;
    endfunction

    // Works out the wheel command for one heading word and advances the
    // drive-side flag, exactly as the block is meant to.
    function automatic ddw_pkg::out_word_t compute_wheel_command(ddw_pkg::in_word_t w);
        logic [15:0] diff;
        logic [31:0] ang;
        logic        flip;
        longint      x, y, z, xs, ys, c, s;
        longint      top, look, rad, side, fwd, turn, den;
        ddw_pkg::out_word_t r;
        diff = w.heading_target - w.robot_heading;
        ang = {diff, 16'h0000};
        flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
        if (flip)
            ang = ang + 32'h8000_0000;
        x = 652032874;
        y = 0;
        z = longint'($signed(ang));
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_turns(i);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_turns(i);
            end
        end
        c = (x + 16384) >>> 15;
        s = (y + 16384) >>> 15;
        if (flip)
        begin
            c = -c;
            s = -s;
        end
        if (w.speed_level == 2'd3)
        begin
            top = reg_shadow[ddw_pkg::REG_SLOW_TOP];
            look = reg_shadow[ddw_pkg::REG_SLOW_LOOK];
        end
        else
        begin
            top = reg_shadow[ddw_pkg::REG_FAST_TOP];
            look = reg_shadow[ddw_pkg::REG_FAST_LOOK];
        end
        rad = reg_shadow[ddw_pkg::REG_RADIUS];
        // A zero divisor register behaves as one.
        if (look == 0)
            look = 1;
        if (rad == 0)
            rad = 1;
        if (c > longint'(reg_shadow[ddw_pkg::REG_HYST]))
            side_reverse = 1'b0;
        else if (c < -longint'(reg_shadow[ddw_pkg::REG_HYST]))
            side_reverse = 1'b1;
        side = side_reverse ? 1 : -1;
        fwd = top * c * look;
        turn = side * top * s * longint'(reg_shadow[ddw_pkg::REG_SPACING]);
        den = rad * look * 128;
        r.right_wheel_rate = 16'(rounded_wheel(fwd + turn, den,
                                               reg_shadow[ddw_pkg::REG_LIMIT]));
        r.left_wheel_rate = 16'(rounded_wheel(fwd - turn, den,
                                              reg_shadow[ddw_pkg::REG_LIMIT]));
        r.reverse_drive = side_reverse;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch on word %0d: %s", words_checked, msg);
        mismatches++;
    endtask

    // Writes one register while the block is idle and mirrors it in the shadow.
    task automatic write_register(ddw_pkg::cfg_reg_t idx, logic [15:0] value);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = value;
        if (idx == ddw_pkg::REG_HYST || idx == ddw_pkg::REG_LIMIT)
            reg_shadow[idx] = {1'b0, value[14:0]};
        else
            reg_shadow[idx] = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_heading(ddw_pkg::in_word_t w);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data = w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
        in_ch.valid = 1'b0;
        typed_active = 1'b0;
    endtask

    task automatic wait_until_drained();
        while (pending_wheel_cmds.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Picks a configuration for one random phase. Phase 1 drives every register
    // to all ones (the 15-bit registers see their upper bit masked), phase 2
    // writes all zeros (zero radius and look-ahead), phase 3 restores defaults.
    task automatic configure_phase(int phase);
        logic [15:0] v;
        for (int k = 0; k < 8; k++)
        begin
            unique case (phase)
                1: v = 16'hFFFF;
                2: v = 16'h0000;
                3:
                begin
                    unique case (ddw_pkg::cfg_reg_t'(k))
                        ddw_pkg::REG_FAST_TOP:  v = ddw_pkg::RST_FAST_TOP;
                        ddw_pkg::REG_FAST_LOOK: v = ddw_pkg::RST_FAST_LOOK;
                        ddw_pkg::REG_SLOW_TOP:  v = ddw_pkg::RST_SLOW_TOP;
                        ddw_pkg::REG_SLOW_LOOK: v = ddw_pkg::RST_SLOW_LOOK;
                        ddw_pkg::REG_RADIUS:    v = ddw_pkg::RST_RADIUS;
                        ddw_pkg::REG_SPACING:   v = ddw_pkg::RST_SPACING;
                        ddw_pkg::REG_HYST:      v = {1'b0, ddw_pkg::RST_HYST};
                        default:                v = {1'b0, ddw_pkg::RST_LIMIT};
                    endcase
                end
                default:
                begin
                    unique case (ddw_pkg::cfg_reg_t'(k))
                        ddw_pkg::REG_RADIUS:
                            v = ($urandom_range(0, 3) == 0) ?
                                16'($urandom_range(0, 65535)) :
                                16'($urandom_range(300, 4000));
                        ddw_pkg::REG_HYST:
                            v = 16'($urandom_range(0, 65535));
                        ddw_pkg::REG_LIMIT:
                            v = ($urandom_range(0, 3) == 0) ?
                                16'($urandom_range(0, 65535)) :
                                16'($urandom_range(8000, 32767));
                        ddw_pkg::REG_FAST_LOOK,
                        ddw_pkg::REG_SLOW_LOOK:
                            v = ($urandom_range(0, 1) != 0) ?
                                16'($urandom_range(0, 65535)) :
                                16'($urandom_range(0, 8000));
                        default:
                            v = 16'($urandom_range(0, 65535));
                    endcase
                end
            endcase
            write_register(ddw_pkg::cfg_reg_t'(k), v);
        end
    endtask

    // The receiver stalls at random; the rate is set per phase.
    always @(negedge clk)
    begin
        out_ch.ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Every accepted heading word is predicted at the edge that takes it.
    always @(posedge clk)
    begin
        ddw_pkg::out_word_t pred;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            pred = compute_wheel_command(in_ch.data);
            if (typed_active)
                pending_wheel_cmds.push_back(typed_word);
            else
                pending_wheel_cmds.push_back(pred);
        end
    end

    // Every accepted wheel word is checked against the oldest expected word.
    always @(posedge clk)
    begin
        ddw_pkg::out_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_wheel_cmds.size() == 0)
                report_mismatch("wheel word with no outstanding heading word");
            else
            begin
                want = pending_wheel_cmds.pop_front();
                if (out_ch.data.left_wheel_rate !== want.left_wheel_rate)
                    report_mismatch($sformatf("left_wheel_rate got %0d expected %0d",
                                              out_ch.data.left_wheel_rate,
                                              want.left_wheel_rate));
                if (out_ch.data.right_wheel_rate !== want.right_wheel_rate)
                    report_mismatch($sformatf("right_wheel_rate got %0d expected %0d",
                                              out_ch.data.right_wheel_rate,
                                              want.right_wheel_rate));
                if (out_ch.data.reverse_drive !== want.reverse_drive)
                    report_mismatch($sformatf("reverse_drive got %0d expected %0d",
                                              out_ch.data.reverse_drive,
                                              want.reverse_drive));
            end
            words_checked++;
        end
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        ddw_pkg::in_word_t w;
        int typed_from;
        int kind;
        logic [15:0] base;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        typed_active = 1'b0;
        typed_word = '0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        cycle_count = 0;
        tx_idle_pct = 23;
        rx_idle_pct = 60;
        side_reverse = 1'b0;
        reg_shadow[ddw_pkg::REG_FAST_TOP] = ddw_pkg::RST_FAST_TOP;
        reg_shadow[ddw_pkg::REG_FAST_LOOK] = ddw_pkg::RST_FAST_LOOK;
        reg_shadow[ddw_pkg::REG_SLOW_TOP] = ddw_pkg::RST_SLOW_TOP;
        reg_shadow[ddw_pkg::REG_SLOW_LOOK] = ddw_pkg::RST_SLOW_LOOK;
        reg_shadow[ddw_pkg::REG_RADIUS] = ddw_pkg::RST_RADIUS;
        reg_shadow[ddw_pkg::REG_SPACING] = ddw_pkg::RST_SPACING;
        reg_shadow[ddw_pkg::REG_HYST] = {1'b0, ddw_pkg::RST_HYST};
        reg_shadow[ddw_pkg::REG_LIMIT] = {1'b0, ddw_pkg::RST_LIMIT};

        // Directed rows under the reset configuration: zero error, errors of
        // one unit either way across the wrap, both sides of each quadrant
        // boundary (where the CORDIC pre-rotation by half a turn kicks in),
        // the half-turn error that flips the drive side, and quarter-turn
        // errors where the cosine sits inside the hysteresis band.
        dir_rows.push_back('{16'h0000, 16'h0000, 2'd0, 0, 0, 0, 0});
        dir_rows.push_back('{16'h7FFF, 16'h8000, 2'd1, 0, 0, 0, 0});
        dir_rows.push_back('{16'h8000, 16'h7FFF, 2'd2, 0, 0, 0, 0});
        dir_rows.push_back('{16'h4000, 16'h0000, 2'd0, 0, 0, 0, 0});
        dir_rows.push_back('{16'hC000, 16'h0000, 2'd3, 0, 0, 0, 0});
        dir_rows.push_back('{16'h8000, 16'h0000, 2'd0, 0, 0, 0, 0});
        dir_rows.push_back('{16'h4000, 16'h0000, 2'd3, 0, 0, 0, 0});
        dir_rows.push_back('{16'h3FFF, 16'h0000, 2'd1, 0, 0, 0, 0});
        dir_rows.push_back('{16'h4001, 16'h0000, 2'd2, 0, 0, 0, 0});
        dir_rows.push_back('{16'hBFFF, 16'h0000, 2'd3, 0, 0, 0, 0});
        dir_rows.push_back('{16'hC001, 16'h0000, 2'd0, 0, 0, 0, 0});
        dir_rows.push_back('{16'h2000, 16'hE000, 2'd3, 0, 0, 0, 0});
        dir_rows.push_back('{16'h1000, 16'h0000, 2'd3, 0, 0, 0, 0});
        dir_rows.push_back('{16'hF000, 16'h0000, 2'd1, 0, 0, 0, 0});
        dir_rows.push_back('{16'h6000, 16'h0000, 2'd2, 0, 0, 0, 0});
        dir_rows.push_back('{16'hA000, 16'h0000, 2'd0, 0, 0, 0, 0});
        dir_rows.push_back('{16'hFFFF, 16'hFFFF, 2'd3, 0, 0, 0, 0});
        dir_rows.push_back('{16'h5555, 16'hAAAA, 2'd1, 0, 0, 0, 0});
        // With the wheel limit at zero both wheels read zero, and only the
        // drive side moves: forward on zero error, reverse on a half turn,
        // held on a quarter turn.
        typed_from = dir_rows.size();
        dir_rows.push_back('{16'h0000, 16'h0000, 2'd0, 1, 16'h0, 16'h0, 1'b0});
        dir_rows.push_back('{16'h8000, 16'h0000, 2'd3, 1, 16'h0, 16'h0, 1'b1});
        dir_rows.push_back('{16'h4000, 16'h0000, 2'd1, 1, 16'h0, 16'h0, 1'b1});
        dir_rows.push_back('{16'h1234, 16'h1234, 2'd2, 1, 16'h0, 16'h0, 1'b0});
        dir_rows.push_back('{16'h0000, 16'h8000, 2'd0, 1, 16'h0, 16'h0, 1'b1});

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < dir_rows.size(); i++)
        begin
            if (i == typed_from)
            begin
                wait_until_drained();
                write_register(ddw_pkg::REG_LIMIT, 16'h0000);
            end
            w.heading_target = dir_rows[i].target;
            w.robot_heading = dir_rows[i].heading;
            w.speed_level = dir_rows[i].level;
            typed_active = dir_rows[i].has_typed;
            typed_word.left_wheel_rate = dir_rows[i].left;
            typed_word.right_wheel_rate = dir_rows[i].right;
            typed_word.reverse_drive = dir_rows[i].rev;
            send_heading(w);
        end

        // Random phases: each one reconfigures the block while idle, then
        // sends well-spread headings, headings near the quadrant boundaries
        // and small heading errors.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_until_drained();
            configure_phase(p);
            if (p < 4)
            begin
                tx_idle_pct = 23;
                rx_idle_pct = 60;
            end
            else if (p < 7)
            begin
                tx_idle_pct = 60;
                rx_idle_pct = 23;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                kind = $urandom_range(0, 99);
                w.robot_heading = 16'($urandom_range(0, 65535));
                if (kind < 55)
                    w.heading_target = 16'($urandom_range(0, 65535));
                else if (kind < 85)
                begin
                    base = 16'($urandom_range(0, 3)) << 14;
                    w.heading_target = w.robot_heading + base
                                       + 16'($urandom_range(0, 128)) - 16'd64;
                end
                else
                    w.heading_target = w.robot_heading + 16'($urandom_range(0, 4000))
                                       - 16'd2000;
                w.speed_level = 2'($urandom_range(0, 3));
                send_heading(w);
            end
        end

        while (pending_wheel_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d heading words and checked %0d wheel words over %0d phases,",
                 words_sent, words_checked, NUM_PHASES + 1);
        $display("covering register extremes, quadrant edges and three stall patterns.");
        if (mismatches == 0 && pending_wheel_cmds.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
